// ===== rtl/core/nalspl_pkg.sv =====
`timescale 1ns / 1ps

package nalspl_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned RunWidth  = 16;
   localparam int unsigned TypeWidth = 6;
   localparam int unsigned TypeCount = 64;

   localparam logic [ByteWidth-1:0] ByteZero  = 8'h00;
   localparam logic [ByteWidth-1:0] ByteOne   = 8'h01;
   localparam logic [RunWidth-1:0]  RunMax    = 16'hFFFF;
   localparam logic [ByteWidth-1:0] AvcMask   = 8'h1F;
   localparam logic [ByteWidth-1:0] HevcMask  = 8'h3F;

   typedef struct packed {
      logic [ByteWidth-1:0] stream_byte;
      logic                 buffer_end;
   } req_word_type;

   typedef struct packed {
      logic                 has_byte;
      logic [RunWidth-1:0]  zeros_before;
      logic [ByteWidth-1:0] out_byte;
      logic [TypeWidth-1:0] unit_type;
      logic                 unit_begin;
      logic                 unit_end;
   } rsp_word_type;

   function automatic logic [TypeWidth-1:0] type_of(input logic hevc,
                                                    input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] t;
      begin
         if (hevc) begin
            t = (b >> 1) & HevcMask;
         end else begin
            t = b & AvcMask;
         end
         type_of = t[TypeWidth-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/annexb_nal_unit_splitter.sv =====
`timescale 1ns / 1ps

// Annex-B NAL unit splitter. Takes one stream byte per word and emits at most one
// result word per byte: 00 00 01 start codes split the stream, the first byte after a
// start code gives the unit type (csr_write_data = 1 selects the H.265 header layout),
// and only the first non-empty unit of each type per buffer is passed on. A byte is held
// in the input register, then the parse logic updates the stream state and fills the
// output register, so the block sustains one byte per cycle while rsp_stall is low.
// Write the mode only while the block is idle.
module annexb_nal_unit_splitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  nalspl_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nalspl_pkg::rsp_word_type rsp_word
);
   import nalspl_pkg::*;

   logic         hevc_mode_ff;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         advance;
   logic         out_free;
   logic         step_valid;
   rsp_word_type step_word;

   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         hevc_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         hevc_mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   nalspl_step u_step (
      .clock        (clock),
      .reset        (reset),
      .hevc_mode    (hevc_mode_ff),
      .fire         (advance),
      .word         (in_word_ff),
      .result_valid (step_valid),
      .result       (step_word)
   );

   nalspl_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && step_valid),
      .load_word (step_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .free      (out_free)
   );

endmodule

// ===== rtl/core/nalspl_step.sv =====
`timescale 1ns / 1ps

module nalspl_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hevc_mode,
   input  logic                    fire,
   input  nalspl_pkg::req_word_type word,
   output logic                    result_valid,
   output nalspl_pkg::rsp_word_type result
);
   import nalspl_pkg::*;

   logic [RunWidth-1:0]  zero_run_ff, zero_run_in;
   logic                 inside_unit_ff, inside_unit_in;
   logic                 await_header_ff, await_header_in;
   logic                 keep_unit_ff, keep_unit_in;
   logic                 begin_pending_ff, begin_pending_in;
   logic [TypeWidth-1:0] current_type_ff, current_type_in;
   logic [TypeCount-1:0] types_seen_ff, types_seen_in;

   logic [ByteWidth-1:0] b;
   logic                 last;
   logic                 sync_hit;
   logic [RunWidth-1:0]  run_inc;
   logic                 keep_next;

   assign b        = word.stream_byte;
   assign last     = word.buffer_end;
   assign sync_hit = (b == ByteOne) && (zero_run_ff >= RunWidth'(2));
   assign run_inc  = (zero_run_ff == RunMax) ? zero_run_ff : zero_run_ff + RunWidth'(1);

   always_comb begin
      zero_run_in      = zero_run_ff;
      inside_unit_in   = inside_unit_ff;
      await_header_in  = await_header_ff;
      keep_unit_in     = keep_unit_ff;
      begin_pending_in = begin_pending_ff;
      current_type_in  = current_type_ff;
      types_seen_in    = types_seen_ff;
      keep_next        = keep_unit_ff;
      result_valid     = 1'b0;
      result           = '0;

      if (sync_hit) begin
         if (inside_unit_ff && !await_header_ff && keep_unit_ff) begin
            result_valid      = 1'b1;
            result.unit_type  = current_type_ff;
            result.unit_end   = 1'b1;
         end
         inside_unit_in   = 1'b1;
         await_header_in  = 1'b1;
         begin_pending_in = 1'b1;
         keep_unit_in     = 1'b0;
         zero_run_in      = '0;
      end else if (!inside_unit_ff) begin
         zero_run_in = (b == ByteZero) ? run_inc : '0;
      end else if ((b == ByteZero) && !last) begin
         if (await_header_ff && (zero_run_ff == '0)) begin
            current_type_in = '0;
         end
         zero_run_in = run_inc;
      end else begin
         if (await_header_ff) begin
            if (zero_run_ff == '0) begin
               current_type_in = type_of(hevc_mode, b);
            end
            keep_next       = !types_seen_ff[current_type_in];
            keep_unit_in    = keep_next;
            types_seen_in   = types_seen_ff | (TypeCount'(1) << current_type_in);
            await_header_in = 1'b0;
         end
         if (keep_next) begin
            result_valid        = 1'b1;
            result.has_byte     = 1'b1;
            result.zeros_before = zero_run_ff;
            result.out_byte     = b;
            result.unit_type    = current_type_in;
            result.unit_begin   = begin_pending_ff;
            result.unit_end     = last;
            begin_pending_in    = 1'b0;
         end
         zero_run_in = '0;
      end

      if (last) begin
         zero_run_in      = '0;
         inside_unit_in   = 1'b0;
         await_header_in  = 1'b0;
         keep_unit_in     = 1'b0;
         begin_pending_in = 1'b0;
         current_type_in  = '0;
         types_seen_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff      <= '0;
         inside_unit_ff   <= 1'b0;
         await_header_ff  <= 1'b0;
         keep_unit_ff     <= 1'b0;
         begin_pending_ff <= 1'b0;
         current_type_ff  <= '0;
         types_seen_ff    <= '0;
      end else if (fire) begin
         zero_run_ff      <= zero_run_in;
         inside_unit_ff   <= inside_unit_in;
         await_header_ff  <= await_header_in;
         keep_unit_ff     <= keep_unit_in;
         begin_pending_ff <= begin_pending_in;
         current_type_ff  <= current_type_in;
         types_seen_ff    <= types_seen_in;
      end
   end

   a_begin_has_byte: assert property (@(posedge clock) disable iff (reset)
      fire && result_valid && result.unit_begin |-> result.has_byte)
      else $error("unit begin without payload byte");

   a_close_only: assert property (@(posedge clock) disable iff (reset)
      fire && result_valid && !result.has_byte |->
         result.unit_end && !result.unit_begin && (result.zeros_before == '0))
      else $error("bad close word");

   a_buffer_clear: assert property (@(posedge clock) disable iff (reset)
      fire && word.buffer_end |=>
         (types_seen_ff == '0) && !inside_unit_ff && (zero_run_ff == '0))
      else $error("state not cleared at buffer end");

   a_seen_current: assert property (@(posedge clock) disable iff (reset)
      fire && result_valid && result.has_byte |-> types_seen_in[result.unit_type] || last)
      else $error("emitted type missing from seen map");

endmodule

// ===== rtl/core/nalspl_obuf.sv =====
`timescale 1ns / 1ps

module nalspl_obuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  nalspl_pkg::rsp_word_type load_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nalspl_pkg::rsp_word_type rsp_word,
   output logic                     free
);
   import nalspl_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule
